FILE: src/fpl_pkg.sv
// Shared types and constants for the page frame buffer line plotter.
// No dependencies; used by every module in src.
package fpl_pkg;

  localparam int PANEL_WIDTH_DEF  = 84;
  localparam int PANEL_HEIGHT_DEF = 48;

  localparam int CMDW = 2;
  localparam int XW   = 7;
  localparam int YW   = 6;
  localparam int BIW  = 9;
  localparam int DW   = 8;
  localparam int ERRW = 11;

  typedef enum logic [CMDW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_LINE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load;
    logic adv;
  } walk_ctl_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          last;
  } walk_pos_t;

endpackage

FILE: src/page_framebuffer_line_plotter.sv
// Top level of the page frame buffer line plotter: command decode and store sequencing.
// Depends on fpl_pkg, fpl_store and fpl_walker.
//
// A request is taken when start is high and busy is low. After reset the store
// is cleared by a pass over its PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes (504 at
// the default size) with busy high; a clear request runs the same pass. Set
// pixel does one point and a line max(|dx|,|dy|)+1 points, each a read then a
// write, since every point is a read-modify-write through the store's single
// read and single write port. A read request keeps busy low: out_valid and
// out_read_byte appear for one cycle in the cycle after acceptance and cannot
// be held, so the receiver must take them then.
module page_framebuffer_line_plotter #(
  parameter int PANEL_WIDTH  = fpl_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = fpl_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [fpl_pkg::CMDW-1:0] in_cmd,
  input  logic [fpl_pkg::XW-1:0]   in_x_a,
  input  logic [fpl_pkg::YW-1:0]   in_y_a,
  input  logic [fpl_pkg::XW-1:0]   in_x_b,
  input  logic [fpl_pkg::YW-1:0]   in_y_b,
  input  logic [fpl_pkg::BIW-1:0]  in_byte_index,
  output logic                     out_valid,
  output logic [fpl_pkg::DW-1:0]   out_read_byte
);

  localparam int PAGES = (PANEL_HEIGHT + 7) / 8;
  localparam int DEPTH = PANEL_WIDTH * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = fpl_pkg::DW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLR,
    ST_LRD,
    ST_LWR
  } state_t;

  state_t                st_r, st_nxt;
  logic [AW-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  rd_ok_r, rd_ok_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic [DW-1:0]         mask_r, mask_nxt;
  logic                  on_r, on_nxt;

  fpl_pkg::walk_ctl_t    wctl;
  fpl_pkg::walk_pos_t    wpos;
  logic                  accept;
  fpl_pkg::cmd_t         cmd;
  logic [fpl_pkg::XW-1:0] ld_xb;
  logic [fpl_pkg::YW-1:0] ld_yb;
  logic [15:0]           pix_addr;
  logic                  pix_on;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DW-1:0]         mem_wdata, mem_rdata;

  assign accept = start && (st_r == ST_IDLE);
  assign cmd    = fpl_pkg::cmd_t'(in_cmd);

  assign pix_on   = (32'(wpos.x) < PANEL_WIDTH) && (32'(wpos.y) < PANEL_HEIGHT);
  assign pix_addr = 16'(wpos.x) + 16'(wpos.y[fpl_pkg::YW-1:3]) * 16'(PANEL_WIDTH);

  always_comb begin
    st_nxt        = st_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    rd_ok_nxt     = rd_ok_r;
    addr_nxt      = addr_r;
    mask_nxt      = mask_r;
    on_nxt        = on_r;
    wctl.load     = 1'b0;
    wctl.adv      = 1'b0;
    ld_xb         = in_x_b;
    ld_yb         = in_y_b;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = mem_rdata | mask_r;
    mem_re        = 1'b0;
    mem_raddr     = AW'(in_byte_index);

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            fpl_pkg::CMD_CLEAR: begin
              st_nxt      = ST_CLR;
              clr_cnt_nxt = '0;
            end
            fpl_pkg::CMD_PIXEL: begin
              ld_xb     = in_x_a;
              ld_yb     = in_y_a;
              wctl.load = 1'b1;
              st_nxt    = ST_LRD;
            end
            fpl_pkg::CMD_LINE: begin
              wctl.load = 1'b1;
              st_nxt    = ST_LRD;
            end
            fpl_pkg::CMD_READ: begin
              mem_re        = 1'b1;
              out_valid_nxt = 1'b1;
              rd_ok_nxt     = (32'(in_byte_index) < DEPTH);
            end
            default: begin
              st_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (32'(clr_cnt_r) == DEPTH - 1) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_LRD: begin
        mem_re    = 1'b1;
        mem_raddr = pix_addr[AW-1:0];
        addr_nxt  = pix_addr[AW-1:0];
        mask_nxt  = DW'(1) << wpos.y[2:0];
        on_nxt    = pix_on;
        st_nxt    = ST_LWR;
      end
      ST_LWR: begin
        mem_we   = on_r;
        wctl.adv = 1'b1;
        st_nxt   = wpos.last ? ST_IDLE : ST_LRD;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ok_r     <= rd_ok_nxt;
    end
    addr_r <= addr_nxt;
    mask_r <= mask_nxt;
    on_r   <= on_nxt;
  end

  fpl_walker u_walker (
    .clk (clk),
    .ctl (wctl),
    .x_a (in_x_a),
    .y_a (in_y_a),
    .x_b (ld_xb),
    .y_b (ld_yb),
    .pos (wpos)
  );

  fpl_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy          = (st_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_byte = rd_ok_r ? mem_rdata : '0;

  a_out_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && (in_cmd == fpl_pkg::CMD_READ)))
    else $error("result without a read request");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_LWR) |-> ($past(st_r) == ST_LRD))
    else $error("pixel write without its read");

  a_store_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((st_r == ST_CLR) || (st_r == ST_LWR)))
    else $error("store written outside clear or pixel write");

  a_clear_runs: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_CLR) && (32'(clr_cnt_r) != DEPTH - 1)) |=> (st_r == ST_CLR))
    else $error("clearing pass cut short");

endmodule

FILE: src/fpl_store.sv
// Frame store: one write port, one read port, registered read.
// Depends on fpl_pkg for the data width.
module fpl_store #(
  parameter int DEPTH = 504,
  parameter int AW    = 9
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [fpl_pkg::DW-1:0] wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [fpl_pkg::DW-1:0] rdata
);

  logic [fpl_pkg::DW-1:0] mem [DEPTH];
  logic [fpl_pkg::DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/fpl_walker.sv
// Bresenham point walker: holds the current point, doubled error and step signs.
// Depends on fpl_pkg for field widths and the control and position structs.
module fpl_walker (
  input  logic                   clk,
  input  fpl_pkg::walk_ctl_t     ctl,
  input  logic [fpl_pkg::XW-1:0] x_a,
  input  logic [fpl_pkg::YW-1:0] y_a,
  input  logic [fpl_pkg::XW-1:0] x_b,
  input  logic [fpl_pkg::YW-1:0] y_b,
  output fpl_pkg::walk_pos_t     pos
);

  localparam int XW   = fpl_pkg::XW;
  localparam int YW   = fpl_pkg::YW;
  localparam int ERRW = fpl_pkg::ERRW;

  logic [XW-1:0]          x_r, x_nxt, xe_r, xe_nxt;
  logic [YW-1:0]          y_r, y_nxt, ye_r, ye_nxt;
  logic                   sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [ERRW-1:0] dx_r, dx_nxt, dy_r, dy_nxt, err_r, err_nxt;
  logic signed [ERRW-1:0] xa_e, xb_e, ya_e, yb_e, dx_ld, dy_ld;
  logic                   xs, ys;

  always_comb begin
    xa_e  = ERRW'(x_a);
    xb_e  = ERRW'(x_b);
    ya_e  = ERRW'(y_a);
    yb_e  = ERRW'(y_b);
    dx_ld = (x_b >= x_a) ? (xb_e - xa_e) : (xa_e - xb_e);
    dy_ld = (y_b >= y_a) ? (ya_e - yb_e) : (yb_e - ya_e);
    xs    = (err_r >= dy_r);
    ys    = (err_r <= dx_r);

    x_nxt   = x_r;
    y_nxt   = y_r;
    xe_nxt  = xe_r;
    ye_nxt  = ye_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    dx_nxt  = dx_r;
    dy_nxt  = dy_r;
    err_nxt = err_r;
    if (ctl.load) begin
      x_nxt   = x_a;
      y_nxt   = y_a;
      xe_nxt  = x_b;
      ye_nxt  = y_b;
      sx_nxt  = (x_b < x_a);
      sy_nxt  = (y_b < y_a);
      dx_nxt  = dx_ld;
      dy_nxt  = dy_ld;
      err_nxt = (dx_ld <<< 1) + (dy_ld <<< 1);
    end else if (ctl.adv) begin
      if (xs) begin
        x_nxt = sx_r ? (x_r - XW'(1)) : (x_r + XW'(1));
      end
      if (ys) begin
        y_nxt = sy_r ? (y_r - YW'(1)) : (y_r + YW'(1));
      end
      err_nxt = err_r + (xs ? (dy_r <<< 1) : '0) + (ys ? (dx_r <<< 1) : '0);
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    xe_r  <= xe_nxt;
    ye_r  <= ye_nxt;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    err_r <= err_nxt;
  end

  assign pos.x    = x_r;
  assign pos.y    = y_r;
  assign pos.last = (xs && (x_r == xe_r)) || (ys && (y_r == ye_r));

endmodule

FILE: test/page_framebuffer_line_plotter_tb.sv
// Self-checking testbench for page_framebuffer_line_plotter: sends clear, pixel, line and read
// requests and checks every read byte against a page-layout pixel image kept in the bench.
// Depends on fpl_pkg and the page_framebuffer_line_plotter RTL.
module page_framebuffer_line_plotter_tb;

  localparam int CMDW          = fpl_pkg::CMDW;
  localparam int XW            = fpl_pkg::XW;
  localparam int YW            = fpl_pkg::YW;
  localparam int BIW           = fpl_pkg::BIW;
  localparam int DW            = fpl_pkg::DW;
  localparam int COLS          = 84;
  localparam int ROWS          = 48;
  localparam int IMAGE_BYTES   = COLS * ((ROWS + 7) / 8);
  localparam int RANDOM_REQS   = 1200;
  localparam int PHASE_LEN     = 150;
  localparam int QUIET_LIMIT   = 20000;
  localparam int DRAIN_LIMIT   = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    fpl_pkg::cmd_t  cmd;
    logic [XW-1:0]  x_a;
    logic [YW-1:0]  y_a;
    logic [XW-1:0]  x_b;
    logic [YW-1:0]  y_b;
    logic [BIW-1:0] byte_index;
    int             idle_pct;
  } plot_req_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [CMDW-1:0]  in_cmd = '0;
  logic [XW-1:0]    in_x_a = '0;
  logic [YW-1:0]    in_y_a = '0;
  logic [XW-1:0]    in_x_b = '0;
  logic [YW-1:0]    in_y_b = '0;
  logic [BIW-1:0]   in_byte_index = '0;
  logic             out_valid;
  logic [DW-1:0]    out_read_byte;

  plot_req_t        pending[$];
  logic [DW-1:0]    read_bytes_due[$];
  logic [DW-1:0]    pixel_image [IMAGE_BYTES];
  int               phase_idle [3] = '{0, 82, 8};
  int               bad_count = 0;
  int               quiet_cycles = 0;

  page_framebuffer_line_plotter u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_x_a        (in_x_a),
    .in_y_a        (in_y_a),
    .in_x_b        (in_x_b),
    .in_y_b        (in_y_b),
    .in_byte_index (in_byte_index),
    .out_valid     (out_valid),
    .out_read_byte (out_read_byte)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    foreach (pixel_image[i]) pixel_image[i] = '0;
  end

  function automatic void mark_pixel(int x, int y);
    if (x < COLS && y < ROWS) pixel_image[x + (y / 8) * COLS][y % 8] = 1'b1;
  endfunction

  function automatic void trace_line(int x0, int y0, int x1, int y1);
    int run;
    int rise;
    int step_x;
    int step_y;
    int err;
    int err_top;
    run    = (x1 >= x0) ? x1 - x0 : x0 - x1;
    rise   = (y1 >= y0) ? y0 - y1 : y1 - y0;
    step_x = (x1 >= x0) ? 1 : -1;
    step_y = (y1 >= y0) ? 1 : -1;
    err    = 2 * run + 2 * rise;
    while (1'b1) begin
      err_top = err;
      mark_pixel(x0, y0);
      if (err_top >= rise) begin
        if (x0 == x1) break;
        err += 2 * rise;
        x0  += step_x;
      end
      if (err_top <= run) begin
        if (y0 == y1) break;
        err += 2 * run;
        y0  += step_y;
      end
    end
  endfunction

  function automatic void apply_request(plot_req_t r);
    case (r.cmd)
      fpl_pkg::CMD_CLEAR: foreach (pixel_image[i]) pixel_image[i] = '0;
      fpl_pkg::CMD_PIXEL: mark_pixel(r.x_a, r.y_a);
      fpl_pkg::CMD_LINE:  trace_line(r.x_a, r.y_a, r.x_b, r.y_b);
      default: begin
        if (r.byte_index < IMAGE_BYTES) read_bytes_due.push_back(pixel_image[r.byte_index]);
        else read_bytes_due.push_back('0);
      end
    endcase
  endfunction

  function automatic plot_req_t make_req(fpl_pkg::cmd_t cmd, int xa, int ya, int xb, int yb,
                                         int bi);
    plot_req_t r;
    r.cmd        = cmd;
    r.x_a        = XW'(xa);
    r.y_a        = YW'(ya);
    r.x_b        = XW'(xb);
    r.y_b        = YW'(yb);
    r.byte_index = BIW'(bi);
    r.idle_pct   = 0;
    return r;
  endfunction

  function automatic int coord(int span, int field_max);
    if ($urandom_range(99) < 85) return $urandom_range(span - 1);
    return $urandom_range(field_max);
  endfunction

  function automatic plot_req_t random_req(int idle_pct);
    plot_req_t r;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 3) r.cmd = fpl_pkg::CMD_CLEAR;
    else if (pick < 25) r.cmd = fpl_pkg::CMD_PIXEL;
    else if (pick < 62) r.cmd = fpl_pkg::CMD_LINE;
    else r.cmd = fpl_pkg::CMD_READ;
    r.x_a = XW'(coord(COLS, (1 << XW) - 1));
    r.y_a = YW'(coord(ROWS, (1 << YW) - 1));
    r.x_b = XW'(coord(COLS, (1 << XW) - 1));
    r.y_b = YW'(coord(ROWS, (1 << YW) - 1));
    if ($urandom_range(99) < 90) r.byte_index = BIW'($urandom_range(IMAGE_BYTES - 1));
    else r.byte_index = BIW'($urandom_range((1 << BIW) - 1));
    r.idle_pct = idle_pct;
    return r;
  endfunction

  // Hold each request until taken, then pick a gap before the next one.
  always @(posedge clk) begin
    logic taken;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = (start === 1'b1) && (busy === 1'b0);
      if (taken) apply_request(pending.pop_front());
      if (!start || taken) begin
        if (pending.size() != 0 && $urandom_range(99) >= pending[0].idle_pct) begin
          in_cmd        <= pending[0].cmd;
          in_x_a        <= pending[0].x_a;
          in_y_a        <= pending[0].y_a;
          in_x_b        <= pending[0].x_b;
          in_y_b        <= pending[0].y_b;
          in_byte_index <= pending[0].byte_index;
          start         <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [DW-1:0] due;
    if (rst_n && out_valid === 1'b1) begin
      if (read_bytes_due.size() == 0) begin
        if (bad_count < MAX_REPORTS) $display("unexpected read result: got %02h", out_read_byte);
        bad_count++;
      end else begin
        due = read_bytes_due.pop_front();
        if (out_read_byte !== due) begin
          if (bad_count < MAX_REPORTS)
            $display("read_byte mismatch: expected %02h got %02h", due, out_read_byte);
          bad_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("page_framebuffer_line_plotter_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int drain;
    pending.push_back(make_req(fpl_pkg::CMD_READ,    0,  0,   0,  0,   0));
    pending.push_back(make_req(fpl_pkg::CMD_READ,    0,  0,   0,  0, 503));
    pending.push_back(make_req(fpl_pkg::CMD_READ,    0,  0,   0,  0, 504));
    pending.push_back(make_req(fpl_pkg::CMD_READ,    0,  0,   0,  0, 511));
    pending.push_back(make_req(fpl_pkg::CMD_PIXEL,   0,  0,   0,  0,   0));
    pending.push_back(make_req(fpl_pkg::CMD_PIXEL,  83, 47,   0,  0,   0));
    pending.push_back(make_req(fpl_pkg::CMD_PIXEL,  84,  0,   0,  0,   0));
    pending.push_back(make_req(fpl_pkg::CMD_PIXEL,   0, 48,   0,  0,   0));
    pending.push_back(make_req(fpl_pkg::CMD_PIXEL, 127, 63, 127, 63, 511));
    pending.push_back(make_req(fpl_pkg::CMD_READ,    0,  0,   0,  0,   0));
    pending.push_back(make_req(fpl_pkg::CMD_READ,    0,  0,   0,  0, 503));
    pending.push_back(make_req(fpl_pkg::CMD_LINE,   10,  3,  60, 20,   0));
    pending.push_back(make_req(fpl_pkg::CMD_LINE,   70, 45,   5,  2,   0));
    pending.push_back(make_req(fpl_pkg::CMD_LINE,   20,  0,  25, 47,   0));
    pending.push_back(make_req(fpl_pkg::CMD_LINE,   40, 10,  40, 10,   0));
    pending.push_back(make_req(fpl_pkg::CMD_LINE,   80, 40, 127, 63,   0));
    pending.push_back(make_req(fpl_pkg::CMD_LINE,    0, 47,  83,  0,   0));
    pending.push_back(make_req(fpl_pkg::CMD_READ,    0,  0,   0,  0,  10));
    pending.push_back(make_req(fpl_pkg::CMD_READ,    0,  0,   0,  0, 124));
    pending.push_back(make_req(fpl_pkg::CMD_READ,    0,  0,   0,  0, 500));
    pending.push_back(make_req(fpl_pkg::CMD_READ,    0,  0,   0,  0, 440));
    pending.push_back(make_req(fpl_pkg::CMD_CLEAR,   0,  0,   0,  0,   0));
    pending.push_back(make_req(fpl_pkg::CMD_READ,    0,  0,   0,  0,   0));
    pending.push_back(make_req(fpl_pkg::CMD_READ,    0,  0,   0,  0, 124));
    for (int i = 0; i < RANDOM_REQS; i++)
      pending.push_back(random_req(phase_idle[(i / PHASE_LEN) % 3]));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || start) @(posedge clk);
    drain = 0;
    while (read_bytes_due.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (read_bytes_due.size() != 0) $display("%0d read results never arrived", read_bytes_due.size());
    if (bad_count == 0 && read_bytes_due.size() == 0) begin
      $display("page_framebuffer_line_plotter_tb: clean");
    end else begin
      $display("page_framebuffer_line_plotter_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
src/fpl_pkg.sv
src/fpl_store.sv
src/fpl_walker.sv
src/page_framebuffer_line_plotter.sv
test/page_framebuffer_line_plotter_tb.sv
